>>> sv/aisenc_pkg.sv
// Shared constants, command word type and character helpers for the AIVDM encoder.
package aisenc_pkg;

  localparam int CHARS_PER_PART  = 60;
  localparam int MAX_FRAME_BYTES = 255;
  localparam int MAX_RESULTS     = 32;
  localparam int PART_MAX        = 9;
  localparam int SEQ_WRAP        = 9;
  localparam int LEN_CAP_PARTS   = (27 * CHARS_PER_PART) / 4;
  localparam int LEN_LIMIT       = (MAX_FRAME_BYTES < LEN_CAP_PARTS) ? MAX_FRAME_BYTES
                                                                     : LEN_CAP_PARTS;
  localparam int NCH_W           = 9;
  localparam int DIV6_SHIFT      = 24;
  localparam int DIV6_MUL        = ((1 << DIV6_SHIFT) + 5) / 6;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);

  localparam logic [6:0] ARMOR_LOW_OFS  = 7'd48;
  localparam logic [6:0] ARMOR_HIGH_OFS = 7'd56;
  localparam logic [5:0] ARMOR_SPLIT    = 6'd40;

  localparam logic [6:0] CH_BANG  = 7'h21;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_I     = 7'h49;
  localparam logic [6:0] CH_V     = 7'h56;
  localparam logic [6:0] CH_D     = 7'h44;
  localparam logic [6:0] CH_M     = 7'h4D;
  localparam logic [6:0] CH_COMMA = 7'h2C;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_ONE   = 7'h31;
  localparam logic [6:0] CH_STAR  = 7'h2A;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_LF    = 7'h0A;

  localparam logic [3:0] HDR_LAST_SPLIT  = 4'd14;
  localparam logic [3:0] HDR_LAST_SINGLE = 4'd13;
  localparam logic [3:0] TRL_LAST        = 4'd6;

  // One classified input word, handed from the front to the character sequencer
  typedef struct packed {
    logic       start;
    logic       split;
    logic [3:0] ptot;
    logic [3:0] seq;
    logic       chan;
    logic       two;
    logic [5:0] c0;
    logic [5:0] c1;
    logic       last;
    logic [2:0] fill;
  } cmd_t;

  function automatic logic [6:0] armor(input logic [5:0] v);
    logic [6:0] r;
    if (v >= ARMOR_SPLIT) r = {1'b0, v} + ARMOR_HIGH_OFS;
    else                  r = {1'b0, v} + ARMOR_LOW_OFS;
    return r;
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] v);
    logic [6:0] r;
    if (v < 4'd10) r = CH_ZERO + {3'b0, v};
    else           r = CH_A + {3'b0, v} - 7'd10;
    return r;
  endfunction

  function automatic logic [6:0] hdr_char(input logic [3:0] idx, input logic split,
                                          input logic [3:0] ptot, input logic [3:0] pn,
                                          input logic [3:0] seq, input logic chan);
    logic [6:0] r;
    unique case (idx)
      4'd0:    r = CH_BANG;
      4'd1:    r = CH_A;
      4'd2:    r = CH_I;
      4'd3:    r = CH_V;
      4'd4:    r = CH_D;
      4'd5:    r = CH_M;
      4'd6:    r = CH_COMMA;
      4'd7:    r = split ? CH_ZERO + {3'b0, ptot} : CH_ONE;
      4'd8:    r = CH_COMMA;
      4'd9:    r = split ? CH_ZERO + {3'b0, pn} : CH_ONE;
      4'd10:   r = CH_COMMA;
      4'd11:   r = split ? CH_ZERO + {3'b0, seq} : CH_COMMA;
      4'd12:   r = split ? CH_COMMA : CH_A + {6'b0, chan};
      4'd13:   r = split ? CH_A + {6'b0, chan} : CH_COMMA;
      default: r = CH_COMMA;
    endcase
    return r;
  endfunction

endpackage

>>> sv/aisenc_ifs.sv
// Valid/ready channel interfaces for frame bytes in and NMEA characters out.
interface aisenc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       first_byte;
  logic [7:0] message_bytes;
  logic       channel;

  modport source(output valid, payload_byte, first_byte, message_bytes, channel,
                 input ready);
  modport sink(input valid, payload_byte, first_byte, message_bytes, channel,
               output ready);
endinterface

interface aisenc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       sentence_end;
  logic       run_last;

  modport source(output valid, out_char, sentence_end, run_last, input ready);
  modport sink(input valid, out_char, sentence_end, run_last, output ready);
endinterface

>>> sv/aisenc_fifo.sv
// Short command queue between the byte classifier and the character sequencer.
module aisenc_fifo
  import aisenc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, wp_nxt;
  logic [QPTR_W-1:0]   rp_r, rp_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> sv/aisenc_front.sv
// Front end: takes frame bytes, tracks frame state and cuts bits into 6-bit commands.
module aisenc_front
  import aisenc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  aisenc_in_if.sink   in_ch,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_data
);

  // input stage
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_first_r;
  logic [7:0]       s1_len_r;
  logic [NCH_W-1:0] s1_nch_r;
  logic             s1_chan_r;

  // frame state
  logic [7:0]       bl_r;
  logic [3:0]       rb_r;
  logic [2:0]       rc_r;
  logic             split_r;
  logic [3:0]       seq_r;

  logic [7:0]       len_eff;
  logic [10:0]      bits_x;
  logic [32:0]      prod;
  logic             consume;
  logic             active;
  logic [7:0]       bl_cur;
  logic [3:0]       rb_cur;
  logic [2:0]       rc_cur;
  logic             split_cur;
  logic [3:0]       ptot;
  logic [11:0]      acc;
  logic [3:0]       cnt;
  logic             two;
  logic [5:0]       v0, v1, pad;
  logic [2:0]       rc_new;
  logic [3:0]       rem;
  logic             last;
  logic             has_pad;

  assign in_ch.ready = !s1_valid_r || !q_full;

  always_comb begin
    len_eff = (in_ch.message_bytes == 8'd0) ? 8'd1 : in_ch.message_bytes;
    if (len_eff > 8'(LEN_LIMIT)) len_eff = 8'(LEN_LIMIT);
    // ceil(8*len/6) by reciprocal multiply
    bits_x = {len_eff, 3'b000} + 11'd5;
    prod   = 33'(bits_x) * 33'(DIV6_MUL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r  <= in_ch.payload_byte;
      s1_first_r <= in_ch.first_byte;
      s1_len_r   <= len_eff;
      s1_nch_r   <= prod[DIV6_SHIFT +: NCH_W];
      s1_chan_r  <= in_ch.channel;
    end
  end

  always_comb begin
    consume   = s1_valid_r && !q_full;
    active    = s1_first_r || (bl_r != 8'd0);
    bl_cur    = s1_first_r ? s1_len_r : bl_r;
    rb_cur    = s1_first_r ? 4'd0 : rb_r;
    rc_cur    = s1_first_r ? 3'd0 : rc_r;
    split_cur = s1_first_r ? (s1_nch_r > NCH_W'(CHARS_PER_PART + 1)) : split_r;

    ptot = 4'd1;
    for (int k = 1; k < PART_MAX; k++) begin
      if (s1_nch_r > NCH_W'(k * CHARS_PER_PART)) ptot = ptot + 4'd1;
    end

    acc = {rb_cur, s1_byte_r};
    cnt = {1'b0, rc_cur} + 4'd8;
    two = 1'b0;
    v1  = 6'd0;
    case (cnt)
      4'd12: begin
        two    = 1'b1;
        v0     = acc[11:6];
        v1     = acc[5:0];
        rc_new = 3'd0;
        rem    = 4'd0;
      end
      4'd10: begin
        v0     = acc[9:4];
        rc_new = 3'd4;
        rem    = acc[3:0];
      end
      default: begin
        v0     = acc[7:2];
        rc_new = 3'd2;
        rem    = {2'b00, acc[1:0]};
      end
    endcase

    // pad the leftover bits with zeros up to six
    pad     = (rc_new == 3'd4) ? {rem, 2'b00} : {rem[1:0], 4'b0000};
    last    = (bl_cur == 8'd1);
    has_pad = last && (rc_new != 3'd0);

    q_push       = consume && active;
    q_data.start = s1_first_r;
    q_data.split = split_cur;
    q_data.ptot  = ptot;
    q_data.seq   = seq_r;
    q_data.chan  = s1_chan_r;
    q_data.two   = two || has_pad;
    q_data.c0    = v0;
    q_data.c1    = two ? v1 : pad;
    q_data.last  = last;
    q_data.fill  = has_pad ? 3'd6 - rc_new : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_r    <= '0;
      rb_r    <= '0;
      rc_r    <= '0;
      split_r <= 1'b0;
      seq_r   <= '0;
    end else if (q_push) begin
      bl_r    <= bl_cur - 8'd1;
      rb_r    <= last ? 4'd0 : rem;
      rc_r    <= last ? 3'd0 : rc_new;
      split_r <= split_cur;
      if (last && split_cur) begin
        seq_r <= (seq_r >= 4'(SEQ_WRAP)) ? 4'd0 : seq_r + 4'd1;
      end
    end
  end

endmodule

>>> sv/aisenc_back.sv
// Back end: steps header, armored data and trailer; one character a cycle unless stalled.
module aisenc_back
  import aisenc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  cmd_t          q_data,
  output logic          q_pop,
  aisenc_out_if.source  out_ch
);

  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_DAT = 2'd1;
  localparam logic [1:0] PH_TRL = 2'd2;

  logic       busy_r;
  cmd_t       cmd_r;
  logic [1:0] ph_r, ph_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [1:0] dsel_r, dsel_nxt;
  logic       fin_r, fin_nxt;
  logic [7:0] cs_r, cs_nxt;
  logic [5:0] pcc_r, pcc_nxt;
  logic [3:0] pn_r, pn_nxt;
  logic       fsplit_r;
  logic [3:0] ptot_r;
  logic [3:0] fseq_r;
  logic       chan_r;
  logic [5:0] cnt_r, cnt_nxt;

  logic       ov_r;
  logic [6:0] oc_r;
  logic       oe_r;
  logic       ol_r;

  logic       adv;
  logic       done;
  logic [6:0] ch;
  logic       summed;
  logic       cs_clr;
  logic [1:0] nd;
  logic [5:0] pcc_inc;
  logic       final_char;
  logic [3:0] hdr_last;

  assign out_ch.valid        = ov_r;
  assign out_ch.out_char     = oc_r;
  assign out_ch.sentence_end = oe_r;
  assign out_ch.run_last     = ol_r;

  assign adv   = busy_r && (!ov_r || out_ch.ready);
  assign q_pop = !q_empty && (!busy_r || (adv && done));

  always_comb begin
    ch         = CH_COMMA;
    summed     = 1'b0;
    cs_clr     = 1'b0;
    done       = 1'b0;
    ph_nxt     = ph_r;
    idx_nxt    = idx_r;
    dsel_nxt   = dsel_r;
    fin_nxt    = fin_r;
    pn_nxt     = pn_r;
    pcc_nxt    = pcc_r;
    nd         = cmd_r.two ? 2'd2 : 2'd1;
    pcc_inc    = pcc_r + 6'd1;
    final_char = 1'b0;
    hdr_last   = fsplit_r ? HDR_LAST_SPLIT : HDR_LAST_SINGLE;

    unique case (ph_r)
      PH_HDR: begin
        ch     = hdr_char(idx_r, fsplit_r, ptot_r, pn_r, fseq_r, chan_r);
        summed = (idx_r != 4'd0);
        if (idx_r == 4'd0) begin
          cs_clr  = 1'b1;
          pcc_nxt = 6'd0;
        end
        if (idx_r == hdr_last) begin
          idx_nxt = 4'd0;
          if (dsel_r < nd) ph_nxt = PH_DAT;
          else             done   = 1'b1;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      PH_DAT: begin
        ch         = armor(dsel_r[0] ? cmd_r.c1 : cmd_r.c0);
        summed     = 1'b1;
        pcc_nxt    = pcc_inc;
        dsel_nxt   = dsel_r + 2'd1;
        final_char = cmd_r.last && (dsel_nxt == nd);
        // close the part early when it is full and more characters follow
        if (fsplit_r && (pcc_inc >= 6'(CHARS_PER_PART)) && !final_char) begin
          ph_nxt  = PH_TRL;
          idx_nxt = 4'd0;
          fin_nxt = 1'b0;
        end else if (dsel_nxt < nd) begin
          ph_nxt = PH_DAT;
        end else if (cmd_r.last) begin
          ph_nxt  = PH_TRL;
          idx_nxt = 4'd0;
          fin_nxt = 1'b1;
        end else begin
          done = 1'b1;
        end
      end
      PH_TRL: begin
        case (idx_r)
          4'd0:    ch = CH_COMMA;
          4'd1:    ch = CH_ZERO + {4'b0, (fin_r ? cmd_r.fill : 3'd0)};
          4'd2:    ch = CH_STAR;
          4'd3:    ch = hex_char(cs_r[7:4]);
          4'd4:    ch = hex_char(cs_r[3:0]);
          4'd5:    ch = CH_CR;
          default: ch = CH_LF;
        endcase
        summed = (idx_r < 4'd2);
        if (idx_r == TRL_LAST) begin
          idx_nxt = 4'd0;
          if (fin_r) begin
            done = 1'b1;
          end else begin
            pn_nxt = pn_r + 4'd1;
            ph_nxt = PH_HDR;
          end
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      default: begin
        ph_nxt = PH_HDR;
      end
    endcase

    if (cs_clr)      cs_nxt = 8'd0;
    else if (summed) cs_nxt = cs_r ^ {1'b0, ch};
    else             cs_nxt = cs_r;

    cnt_nxt = (cnt_r < 6'(MAX_RESULTS)) ? cnt_r + 6'd1 : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ph_r     <= PH_HDR;
      idx_r    <= '0;
      dsel_r   <= '0;
      fin_r    <= 1'b0;
      cs_r     <= '0;
      pcc_r    <= '0;
      pn_r     <= '0;
      fsplit_r <= 1'b0;
      ptot_r   <= '0;
      fseq_r   <= '0;
      chan_r   <= 1'b0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (adv) begin
        fin_r <= fin_nxt;
        cs_r  <= cs_nxt;
        pcc_r <= pcc_nxt;
        // drop characters past the per-word limit
        ov_r  <= (cnt_r < 6'(MAX_RESULTS));
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end

      if (q_pop) begin
        busy_r <= 1'b1;
        ph_r   <= q_data.start ? PH_HDR : PH_DAT;
        idx_r  <= '0;
        dsel_r <= '0;
        cnt_r  <= '0;
        if (q_data.start) begin
          fsplit_r <= q_data.split;
          ptot_r   <= q_data.ptot;
          fseq_r   <= q_data.seq;
          chan_r   <= q_data.chan;
          pn_r     <= 4'd1;
        end
      end else if (adv) begin
        ph_r   <= ph_nxt;
        idx_r  <= idx_nxt;
        dsel_r <= dsel_nxt;
        pn_r   <= pn_nxt;
        cnt_r  <= cnt_nxt;
        if (done) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oc_r <= ch;
      oe_r <= (ch == CH_LF);
      ol_r <= done || (cnt_r == 6'(MAX_RESULTS - 1));
    end
  end

endmodule

>>> sv/ais_nmea_sentence_encoder_unit.sv
// An accepted byte word goes through the input register, command queue, command register
// and output register to its first character word. Throughput: one character word a cycle
// unless stalled; one sequencer holds a byte word until its 1 to 24 characters are out.
// The front takes a byte word every cycle while the four-entry command queue has room.
// Reset (synchronous, active low) closes any open frame, empties the queue, clears the
// output valid flag and sets the sequence id to 0.
module ais_nmea_sentence_encoder_unit
  import aisenc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  aisenc_in_if.sink     in_ch,
  aisenc_out_if.source  out_ch
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;

  aisenc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  aisenc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  aisenc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> dv/aivdm_text_monitor.sv
// Predicts the AIVDM text of each byte word and checks every character word against it.
`timescale 1ns / 1ps
module aivdm_text_monitor
  import aisenc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  aisenc_in_if  in_mon,
  aisenc_out_if out_mon,
  output int    fail_count,
  output int    pending_chars
);

  typedef struct packed {
    logic [6:0] ch;
    logic       sentence_end;
    logic       run_last;
  } nmea_char_t;

  nmea_char_t expected_text[$];
  nmea_char_t word_text[$];
  int         fails = 0;

  // Encoder state as seen from outside
  logic [3:0] rsd_bits;
  logic [2:0] rsd_cnt;
  logic [7:0] xsum;
  logic [5:0] part_len;
  logic [3:0] part_no;
  logic [3:0] part_tot;
  logic       split;
  logic [3:0] seq_id;
  logic       chan;
  logic [7:0] bytes_rem;
  logic [8:0] chars_rem;

  function automatic void put_char(input logic [6:0] c, input logic summed);
    nmea_char_t e;
    if (word_text.size() < MAX_RESULTS) begin
      e.ch           = c;
      e.sentence_end = (c == CH_LF);
      e.run_last     = 1'b0;
      word_text.push_back(e);
    end
    if (summed) xsum = xsum ^ {1'b0, c};
  endfunction

  function automatic void put_text(input string s);
    byte b;
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      put_char(b[6:0], 1'b1);
    end
  endfunction

  function automatic logic [6:0] digit_char(input int n);
    return CH_ZERO + 7'(n % 10);
  endfunction

  function automatic logic [6:0] nibble_char(input logic [3:0] v);
    return (v < 4'd10) ? CH_ZERO + 7'(v) : CH_A + 7'(v) - 7'd10;
  endfunction

  function automatic void open_sentence();
    xsum = 8'h00;
    put_char(CH_BANG, 1'b0);
    put_text("AIVDM,");
    if (split) begin
      put_char(digit_char(int'(part_tot)), 1'b1);
      put_char(CH_COMMA, 1'b1);
      put_char(digit_char(int'(part_no)), 1'b1);
      put_char(CH_COMMA, 1'b1);
      put_char(digit_char(int'(seq_id)), 1'b1);
      put_char(CH_COMMA, 1'b1);
    end else begin
      put_text("1,1,,");
    end
    put_char(CH_A + 7'(chan), 1'b1);
    put_char(CH_COMMA, 1'b1);
    part_len = '0;
  endfunction

  function automatic void close_sentence(input int fill);
    put_char(CH_COMMA, 1'b1);
    put_char(digit_char(fill), 1'b1);
    put_char(CH_STAR, 1'b0);
    put_char(nibble_char(xsum[7:4]), 1'b0);
    put_char(nibble_char(xsum[3:0]), 1'b0);
    put_char(CH_CR, 1'b0);
    put_char(CH_LF, 1'b0);
  endfunction

  function automatic void emit_sixbit(input logic [5:0] v);
    put_char((v >= ARMOR_SPLIT) ? {1'b0, v} + ARMOR_HIGH_OFS : {1'b0, v} + ARMOR_LOW_OFS,
             1'b1);
    part_len = part_len + 6'd1;
    if (chars_rem != '0) chars_rem = chars_rem - 9'd1;
    // close a full part and open the next while characters remain
    if (split && part_len >= CHARS_PER_PART && chars_rem != '0) begin
      close_sentence(0);
      part_no = part_no + 4'd1;
      open_sentence();
    end
  endfunction

  function automatic void encode_byte_word(input logic [7:0] pb, input logic fb,
                                           input logic [7:0] mlen, input logic ch);
    int len;
    int nch;
    int acc;
    int cnt;
    int fill;
    word_text.delete();
    if (fb) begin
      len = (mlen == 8'd0) ? 1 : int'(mlen);
      if (len > MAX_FRAME_BYTES) len = MAX_FRAME_BYTES;
      if (len > LEN_CAP_PARTS) len = LEN_CAP_PARTS;
      nch       = (8 * len + 5) / 6;
      bytes_rem = 8'(len);
      chars_rem = 9'(nch);
      split     = (nch > CHARS_PER_PART + 1);
      part_tot  = split ? 4'((nch + CHARS_PER_PART - 1) / CHARS_PER_PART) : 4'd1;
      part_no   = 4'd1;
      chan      = ch;
      rsd_bits  = '0;
      rsd_cnt   = '0;
      open_sentence();
    end
    if (bytes_rem != '0) begin
      acc = (int'(rsd_bits) << 8) | int'(pb);
      cnt = int'(rsd_cnt) + 8;
      while (cnt >= 6) begin
        cnt -= 6;
        emit_sixbit(6'(acc >> cnt));
      end
      rsd_bits  = 4'(acc & ((1 << cnt) - 1));
      rsd_cnt   = 3'(cnt);
      bytes_rem = bytes_rem - 8'd1;
      if (bytes_rem == '0) begin
        fill = 0;
        // pad the leftover bits with zeros into one last character
        if (cnt > 0) begin
          emit_sixbit(6'(int'(rsd_bits) << (6 - cnt)));
          fill = 6 - cnt;
        end
        close_sentence(fill);
        if (split) seq_id = (seq_id >= 4'(SEQ_WRAP)) ? 4'd0 : seq_id + 4'd1;
        rsd_bits  = '0;
        rsd_cnt   = '0;
        chars_rem = '0;
      end
    end
    if (word_text.size() > 0) begin
      word_text[word_text.size() - 1].run_last = 1'b1;
      foreach (word_text[i]) expected_text.push_back(word_text[i]);
    end
  endfunction

  function automatic void check_field(input string what, input logic [6:0] want,
                                      input logic [6:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    nmea_char_t want;
    if (!rst_n) begin
      rsd_bits   = '0;
      rsd_cnt    = '0;
      xsum       = '0;
      part_len   = '0;
      part_no    = '0;
      part_tot   = '0;
      split      = 1'b0;
      seq_id     = '0;
      chan       = 1'b0;
      bytes_rem  = '0;
      chars_rem  = '0;
      expected_text.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        encode_byte_word(in_mon.payload_byte, in_mon.first_byte, in_mon.message_bytes,
                         in_mon.channel);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character word: expected none, got %h end %b last %b",
                   $time, out_mon.out_char, out_mon.sentence_end, out_mon.run_last);
          fails++;
        end else begin
          want = expected_text.pop_front();
          check_field("out_char", want.ch, out_mon.out_char);
          check_field("sentence_end", {6'd0, want.sentence_end}, {6'd0, out_mon.sentence_end});
          check_field("run_last", {6'd0, want.run_last}, {6'd0, out_mon.run_last});
        end
      end
    end
    fail_count    <= fails;
    pending_chars <= expected_text.size();
  end

endmodule

>>> dv/ais_nmea_sentence_encoder_unit_tb.sv
// Testbench top: reset, byte word stimulus, output back-pressure, watchdog and verdict.
`timescale 1ns / 1ps
module ais_nmea_sentence_encoder_unit_tb;

  localparam int RANDOM_WORDS = 430;
  localparam int QUIET_LIMIT  = 2000;

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_idle_pct;
  int   stall_left = 0;
  int   fail_count;
  int   pending_chars;

  aisenc_in_if  in_ch ();
  aisenc_out_if out_ch ();

  ais_nmea_sentence_encoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  aivdm_text_monitor text_mon (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_chars (pending_chars)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_word(input logic [7:0] pb, input logic fb, input logic [7:0] mlen,
                           input logic ch);
    int gap;
    gap = ($urandom_range(0, 99) < in_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.payload_byte  <= pb;
    in_ch.first_byte    <= fb;
    in_ch.message_bytes <= mlen;
    in_ch.channel       <= ch;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      out_ch.ready <= 1'b0;
      stall_left   <= pick_gap() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int   words;
    int   len_code;
    int   eff;
    int   n;
    int   r;
    logic ch;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.payload_byte  = '0;
    in_ch.first_byte    = 1'b0;
    in_ch.message_bytes = '0;
    in_ch.channel       = 1'b0;
    out_ch.ready        = 1'b0;
    in_idle_pct         = 30;
    out_idle_pct        = 30;
    words               = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // stray word with no frame open: drop
    send_word(8'hA5, 1'b0, 8'd3, 1'b1);
    // zero length taken as one byte
    send_word(8'hFF, 1'b1, 8'd0, 1'b1);
    send_word(8'h00, 1'b1, 8'd1, 1'b0);
    send_word(8'hA5, 1'b1, 8'd2, 1'b1);
    send_word(8'h5A, 1'b0, 8'd0, 1'b0);
    send_word(8'hFF, 1'b1, 8'd3, 1'b0);
    send_word(8'hFF, 1'b0, 8'd255, 1'b1);
    send_word(8'hFF, 1'b0, 8'd0, 1'b0);
    // restart a frame before its end
    send_word(8'h80, 1'b1, 8'd10, 1'b0);
    send_word(8'h01, 1'b0, 8'd10, 1'b0);
    send_word(8'h7F, 1'b0, 8'd10, 1'b0);
    send_word(8'h3C, 1'b1, 8'd2, 1'b1);
    send_word(8'hC3, 1'b0, 8'd2, 1'b1);
    // byte past the end of the frame
    send_word(8'h55, 1'b0, 8'd1, 1'b0);
    // longest frame, abandoned after two bytes
    send_word(8'h12, 1'b1, 8'd255, 1'b1);
    send_word(8'hED, 1'b0, 8'd255, 1'b1);
    send_word(8'hFE, 1'b1, 8'd1, 1'b0);

    while (words < RANDOM_WORDS) begin
      r            = $urandom_range(0, 9);
      in_idle_pct  = (r < 2) ? 0 : $urandom_range(5, 50);
      out_idle_pct = (r < 3) ? 0 : $urandom_range(5, 50);
      if ($urandom_range(0, 19) == 0) begin
        // noise: ignored unless a cut-off frame is still open
        repeat ($urandom_range(1, 3)) begin
          send_word(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
      end
      r = $urandom_range(0, 99);
      if (r < 30)      len_code = $urandom_range(0, 6);
      else if (r < 40) len_code = $urandom_range(7, 46);
      else if (r < 90) len_code = $urandom_range(47, 52);
      else if (r < 97) len_code = $urandom_range(53, 254);
      else             len_code = 255;
      eff = (len_code == 0) ? 1 : len_code;
      n   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, eff) : eff;
      // stop near the planned number of words, cutting the last frame short
      if (n > RANDOM_WORDS - words) n = RANDOM_WORDS - words;
      ch  = 1'($urandom_range(0, 1));
      for (int i = 0; i < n; i++) begin
        send_word(8'($urandom_range(0, 255)), (i == 0),
                  (i == 0) ? 8'(len_code) : 8'($urandom_range(0, 255)), ch);
      end
      words += n;
      if (n == eff && $urandom_range(0, 9) == 0) begin
        send_word(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending_chars != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_chars == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/aisenc_pkg.sv
sv/aisenc_ifs.sv
sv/aisenc_fifo.sv
sv/aisenc_front.sv
sv/aisenc_back.sv
sv/ais_nmea_sentence_encoder_unit.sv
dv/aivdm_text_monitor.sv
dv/ais_nmea_sentence_encoder_unit_tb.sv
